// ===== sv/pcm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_pkg
// Shared types and constants of the palette colour matcher.
// ----------------------------------------------------------------------------
package pcm_pkg;

  localparam logic [1:0] KIND_EXACT   = 2'd0;
  localparam logic [1:0] KIND_ALLOC   = 2'd1;
  localparam logic [1:0] KIND_NEAREST = 2'd2;

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_LOAD   = 1'b1;

  localparam logic CFG_PALETTE_SIZE   = 1'b0;
  localparam logic CFG_RESERVED_COUNT = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [7:0]  entry_index;
    logic [31:0] color_rgba;
  } pcm_in_t;

  typedef struct packed {
    logic [7:0] color_index;
    logic [1:0] match_kind;
  } pcm_out_t;

  // search window; the user keeps it fixed per scan, unenforced
  typedef struct packed {
    logic [8:0] used;
    logic [8:0] cap;
    logic [8:0] res_lo;
  } pcm_bounds_t;

  // running state of a lookup as it moves along the row of cells
  typedef struct packed {
    logic        valid;
    logic [23:0] rgb;
    logic        found_a;
    logic [7:0]  idx_a;
    logic        found_r;
    logic [7:0]  idx_r;
    logic [17:0] best_d;
    logic [7:0]  best_i;
  } pcm_token_t;

  typedef struct packed {
    logic        en;
    logic [7:0]  addr;
    logic [31:0] data;
  } pcm_write_t;

endpackage

// ===== sv/pcm_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_cell
// Holds one palette entry; updates the passing lookup with exact-match and
// nearest-distance results for that entry.
// ----------------------------------------------------------------------------
module pcm_cell
  import pcm_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic        clk,
  input  logic        rst,
  input  pcm_write_t  wr,
  input  pcm_bounds_t bounds,
  input  pcm_token_t  tok_in,
  output pcm_token_t  tok_out
);

  localparam logic [8:0] IDX9 = 9'(IDX);
  localparam logic [7:0] IDX8 = 8'(IDX);

  logic [31:0] entry;
  pcm_token_t  tok_next;
  logic [7:0]  dr, dg, db;
  logic [15:0] sq_r, sq_g, sq_b;
  logic [17:0] sq_dist;
  logic        match;

  function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  always_comb begin
    dr      = absdiff(entry[7:0], tok_in.rgb[7:0]);
    dg      = absdiff(entry[15:8], tok_in.rgb[15:8]);
    db      = absdiff(entry[23:16], tok_in.rgb[23:16]);
    sq_r    = {8'h00, dr} * {8'h00, dr};
    sq_g    = {8'h00, dg} * {8'h00, dg};
    sq_b    = {8'h00, db} * {8'h00, db};
    sq_dist = {2'b00, sq_r} + {2'b00, sq_g} + {2'b00, sq_b};
    match   = (entry[23:0] == tok_in.rgb);
    tok_next = tok_in;
    if (!tok_in.found_a && match && (IDX9 < bounds.used)) begin
      tok_next.found_a = 1'b1;
      tok_next.idx_a   = IDX8;
    end
    if (!tok_in.found_r && match && (IDX9 >= bounds.res_lo) && (IDX9 < bounds.cap)) begin
      tok_next.found_r = 1'b1;
      tok_next.idx_r   = IDX8;
    end
    if ((IDX9 < bounds.cap) && (sq_dist < tok_in.best_d)) begin
      tok_next.best_d = sq_dist;
      tok_next.best_i = IDX8;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else if (wr.en && wr.addr == IDX8) begin
      entry <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

// ===== sv/palette_color_match_allocate_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_color_match_allocate_core
// Palette colour matcher and allocator built as a row of entry cells.
// ----------------------------------------------------------------------------
// A lookup goes from start through the token register tok[0], the row of
// cells and the done register; it walks the row of cells, one entry per
// cycle, and busy stays high until the result is shown. A load keeps busy
// low. The result is presented for one cycle only and must be captured then.
module palette_color_match_allocate_core
  import pcm_pkg::*;
#(
  parameter int ENTRIES = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  pcm_in_t    item,
  output logic       busy,
  output logic       done,
  output pcm_out_t   result,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [8:0] cfg_data
);

  localparam int         DEPTH  = (ENTRIES < 256) ? ENTRIES : 256;
  localparam logic [8:0] DEPTH9 = 9'(DEPTH);

  logic [8:0]  palette_size, reserved_count, allocated_count;
  logic [8:0]  cap, res, used;
  logic        full;
  logic        accept;
  logic [7:0]  alpha;
  pcm_bounds_t bounds;
  pcm_write_t  wr;
  pcm_token_t  tok0_next;
  pcm_token_t  tok [DEPTH+1];
  pcm_token_t  tail;

  assign accept = start && !busy;
  assign tail   = tok[DEPTH];

  always_comb begin
    cap  = (palette_size < DEPTH9) ? palette_size : DEPTH9;
    res  = (reserved_count < cap) ? reserved_count : cap;
    used = (allocated_count < cap) ? allocated_count : cap;
    full = ({1'b0, res} + {1'b0, allocated_count}) >= {1'b0, cap};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      palette_size   <= 9'd256;
      reserved_count <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PALETTE_SIZE:   palette_size   <= cfg_data;
        CFG_RESERVED_COUNT: reserved_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // entry write: a load transaction or an allocation at the end of a scan
  always_comb begin
    wr = '0;
    if (accept && item.mode == MODE_LOAD && ({1'b0, item.entry_index} < DEPTH9)) begin
      wr.en   = 1'b1;
      wr.addr = item.entry_index;
      wr.data = item.color_rgba;
    end else if (tail.valid && !tail.found_a && !tail.found_r && !full) begin
      wr.en   = 1'b1;
      wr.addr = allocated_count[7:0];
      wr.data = {alpha, tail.rgb};
    end
  end

  always_ff @(posedge clk) begin
    bounds.used   <= used;
    bounds.cap    <= cap;
    bounds.res_lo <= cap - res;
  end

  always_comb begin
    tok0_next        = '0;
    tok0_next.best_d = '1;
    if (accept && item.mode == MODE_LOOKUP) begin
      tok0_next.valid = 1'b1;
      tok0_next.rgb   = item.color_rgba[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok[0] <= '0;
    end else begin
      tok[0] <= tok0_next;
    end
  end

  // alpha is not kept in the token, so the allocated entry is stored with
  // the alpha of the transaction held here
  always_ff @(posedge clk) begin
    if (accept && item.mode == MODE_LOOKUP) begin
      alpha <= item.color_rgba[31:24];
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    pcm_cell #(.IDX(g)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .wr      (wr),
      .bounds  (bounds),
      .tok_in  (tok[g]),
      .tok_out (tok[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy            <= 1'b0;
      done            <= 1'b0;
      allocated_count <= '0;
    end else if (tail.valid) begin
      busy <= 1'b0;
      done <= 1'b1;
      if (!tail.found_a && !tail.found_r && !full) begin
        allocated_count <= allocated_count + 9'd1;
      end
    end else begin
      done <= 1'b0;
      if (accept && item.mode == MODE_LOOKUP) begin
        busy <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tail.valid) begin
      if (tail.found_a) begin
        result <= '{color_index: tail.idx_a, match_kind: KIND_EXACT};
      end else if (tail.found_r) begin
        result <= '{color_index: tail.idx_r, match_kind: KIND_EXACT};
      end else if (full) begin
        result <= '{color_index: (cap == 9'd0) ? 8'd0 : tail.best_i,
                    match_kind: KIND_NEAREST};
      end else begin
        result <= '{color_index: allocated_count[7:0], match_kind: KIND_ALLOC};
      end
    end
  end

endmodule

// ===== sv/pcm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_checker
// Port-level checks of the palette colour matcher, bound to the top level.
// ----------------------------------------------------------------------------
module pcm_checker
  import pcm_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     start,
  input pcm_in_t  item,
  input logic     busy,
  input logic     done,
  input pcm_out_t result
);

  a_done_ends_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result shown while still busy");

  a_lookup_sets_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.mode == MODE_LOOKUP) |=> busy)
    else $error("lookup transaction did not raise busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("back-to-back results");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.match_kind == KIND_EXACT || result.match_kind == KIND_ALLOC ||
              result.match_kind == KIND_NEAREST)) else $error("bad match kind");

endmodule

bind palette_color_match_allocate_core pcm_checker u_pcm_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .item   (item),
  .busy   (busy),
  .done   (done),
  .result (result)
);
